// ===== rtl/qvs_pkg.sv =====
// Package with the item types, widths, codes and saturation functions of the skinning core.
package qvs_pkg;

	localparam int MAX_BONES_DEF  = 256;
	localparam int INFLUENCES_DEF = 4;
	localparam int PACKED_INFL    = 4;

	localparam int PW    = 32;
	localparam int VW    = 16;
	localparam int WW    = 16;
	localparam int BIW   = 8;
	localparam int PRODW = 2 * VW;
	localparam int M28W  = PRODW + 4;
	localparam int MW    = M28W - 14;
	localparam int PPW   = MW + PW;
	localparam int PSW   = PPW + 2;
	localparam int RPW   = PSW - 14;
	localparam int TPW   = RPW + 1;
	localparam int WPW   = TPW + WW + 1;
	localparam int AW    = WPW + 2;
	localparam int ARW   = AW - 16;
	localparam int NPW   = MW + VW;
	localparam int NSW   = NPW + 2;
	localparam int RNW   = NSW - 14;
	localparam int WNW   = RNW + WW + 1;
	localparam int ANW   = WNW + 2;
	localparam int ANRW  = ANW - 16;

	localparam logic signed [M28W-1:0] ROT_ONE = M28W'(1) <<< 28;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SKIN = 1'b1;

	typedef struct packed {
		logic                    operation;
		logic [BIW-1:0]          bone_slot;
		logic signed [PW-1:0]    pos_x;
		logic signed [PW-1:0]    pos_y;
		logic signed [PW-1:0]    pos_z;
		logic signed [VW-1:0]    vec_x;
		logic signed [VW-1:0]    vec_y;
		logic signed [VW-1:0]    vec_z;
		logic signed [VW-1:0]    quat_w;
		logic [PACKED_INFL*BIW-1:0] influence_bones;
		logic [PACKED_INFL*WW-1:0]  influence_weights;
	} vtx_item_t;

	typedef struct packed {
		logic signed [PW-1:0] out_pos_x;
		logic signed [PW-1:0] out_pos_y;
		logic signed [PW-1:0] out_pos_z;
		logic signed [VW-1:0] out_normal_x;
		logic signed [VW-1:0] out_normal_y;
		logic signed [VW-1:0] out_normal_z;
	} res_item_t;

	typedef struct packed {
		logic signed [VW-1:0] qw;
		logic signed [VW-1:0] qz;
		logic signed [VW-1:0] qy;
		logic signed [VW-1:0] qx;
		logic signed [PW-1:0] tz;
		logic signed [PW-1:0] ty;
		logic signed [PW-1:0] tx;
	} bone_entry_t;

	function automatic logic signed [PW-1:0] sat_pos(input logic signed [ARW-1:0] v);
		logic signed [PW-1:0] r;
		if (&v[ARW-1:PW-1] || ~|v[ARW-1:PW-1]) begin
			r = v[PW-1:0];
		end else begin
			r = v[ARW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [VW-1:0] sat_nacc(input logic signed [ANRW-1:0] v);
		logic signed [VW-1:0] r;
		if (&v[ANRW-1:VW-1] || ~|v[ANRW-1:VW-1]) begin
			r = v[VW-1:0];
		end else begin
			r = v[ANRW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [VW-1:0] sat_rn(input logic signed [RNW-1:0] v);
		logic signed [VW-1:0] r;
		if (&v[RNW-1:VW-1] || ~|v[RNW-1:VW-1]) begin
			r = v[VW-1:0];
		end else begin
			r = v[RNW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== rtl/qvs_palette.sv =====
// One bank of the bone palette: translation and rotation per slot, registered read.
module qvs_palette #(
	parameter int MAX_BONES = qvs_pkg::MAX_BONES_DEF
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [qvs_pkg::BIW-1:0]   wr_idx,
	input  qvs_pkg::bone_entry_t      wr_entry,
	input  logic                      rd_en,
	input  logic [qvs_pkg::BIW-1:0]   rd_idx,
	output qvs_pkg::bone_entry_t      rd_entry
);
	import qvs_pkg::*;

	localparam int IW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

	bone_entry_t mem [MAX_BONES];
	bone_entry_t rd_data_s1;
	logic        oob_s1;

	logic wr_in_range;
	logic rd_in_range;

	assign wr_in_range = {1'b0, wr_idx} < (BIW+1)'(MAX_BONES);
	assign rd_in_range = {1'b0, rd_idx} < (BIW+1)'(MAX_BONES);

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_idx[IW-1:0]] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx[IW-1:0]];
			oob_s1     <= !rd_in_range;
		end
	end

	// A slot beyond the palette reads as a zero entry, which gives the identity rotation.
	assign rd_entry = oob_s1 ? '0 : rd_data_s1;

endmodule

// ===== rtl/qvs_lane.sv =====
// One influence lane: rotation matrix, rotation of position and normal, and weighting.
module qvs_lane (
	input  logic                              clk,
	input  logic                              en,
	input  qvs_pkg::bone_entry_t              entry_s1,
	input  logic signed [qvs_pkg::PW-1:0]     pos_s3 [3],
	input  logic signed [qvs_pkg::VW-1:0]     nrm_s3 [3],
	input  logic [qvs_pkg::WW-1:0]            wt_s5,
	output logic signed [qvs_pkg::WPW-1:0]    wpos_s6 [3],
	output logic signed [qvs_pkg::WNW-1:0]    wnrm_s6 [3],
	output logic signed [qvs_pkg::RNW-1:0]    rn_s6 [3]
);
	import qvs_pkg::*;

	logic signed [PRODW-1:0] prod_s2 [9];
	logic signed [PW-1:0]    t_s2 [3];
	logic signed [PW-1:0]    t_s3 [3];
	logic signed [PW-1:0]    t_s4 [3];
	logic signed [MW-1:0]    m_s3 [9];
	logic signed [PPW-1:0]   pprod_s4 [9];
	logic signed [NPW-1:0]   nprod_s4 [9];
	logic signed [TPW-1:0]   rpt_s5 [3];
	logic signed [RNW-1:0]   rn_s5 [3];

	logic signed [M28W-1:0]  e [9];
	logic signed [M28W-1:0]  m28 [9];
	logic signed [M28W-1:0]  m28r [9];
	logic signed [MW-1:0]    m14 [9];
	logic signed [PSW-1:0]   psum [3];
	logic signed [NSW-1:0]   nsum [3];
	logic signed [RPW-1:0]   rp [3];
	logic signed [TPW-1:0]   rpt [3];
	logic signed [RNW-1:0]   rn [3];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2[0] <= entry_s1.qx * entry_s1.qx;
			prod_s2[1] <= entry_s1.qy * entry_s1.qy;
			prod_s2[2] <= entry_s1.qz * entry_s1.qz;
			prod_s2[3] <= entry_s1.qx * entry_s1.qy;
			prod_s2[4] <= entry_s1.qx * entry_s1.qz;
			prod_s2[5] <= entry_s1.qy * entry_s1.qz;
			prod_s2[6] <= entry_s1.qw * entry_s1.qx;
			prod_s2[7] <= entry_s1.qw * entry_s1.qy;
			prod_s2[8] <= entry_s1.qw * entry_s1.qz;
			t_s2[0]    <= entry_s1.tx;
			t_s2[1]    <= entry_s1.ty;
			t_s2[2]    <= entry_s1.tz;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			e[i] = M28W'(prod_s2[i]);
		end
		m28[0] = ROT_ONE - ((e[1] + e[2]) <<< 1);
		m28[1] = (e[3] - e[8]) <<< 1;
		m28[2] = (e[4] + e[7]) <<< 1;
		m28[3] = (e[3] + e[8]) <<< 1;
		m28[4] = ROT_ONE - ((e[0] + e[2]) <<< 1);
		m28[5] = (e[5] - e[6]) <<< 1;
		m28[6] = (e[4] - e[7]) <<< 1;
		m28[7] = (e[5] + e[6]) <<< 1;
		m28[8] = ROT_ONE - ((e[0] + e[1]) <<< 1);
		for (int i = 0; i < 9; i++) begin
			m28r[i] = m28[i] + (M28W'(1) <<< 13);
			m14[i]  = m28r[i][M28W-1:14];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				m_s3[i] <= m14[i];
			end
			t_s3 <= t_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pprod_s4[3*r+c] <= m_s3[3*r+c] * pos_s3[c];
					nprod_s4[3*r+c] <= m_s3[3*r+c] * nrm_s3[c];
				end
			end
			t_s4 <= t_s3;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			psum[r] = PSW'(pprod_s4[3*r]) + PSW'(pprod_s4[3*r+1]) + PSW'(pprod_s4[3*r+2])
				+ (PSW'(1) <<< 13);
			nsum[r] = NSW'(nprod_s4[3*r]) + NSW'(nprod_s4[3*r+1]) + NSW'(nprod_s4[3*r+2])
				+ (NSW'(1) <<< 13);
			rp[r]   = psum[r][PSW-1:14];
			rn[r]   = nsum[r][NSW-1:14];
			rpt[r]  = TPW'(rp[r]) + TPW'(t_s4[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rpt_s5 <= rpt;
			rn_s5  <= rn;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				if (wt_s5 == '0) begin
					wpos_s6[r] <= '0;
					wnrm_s6[r] <= '0;
				end else begin
					wpos_s6[r] <= WPW'(rpt_s5[r]) * WPW'($signed({1'b0, wt_s5}));
					wnrm_s6[r] <= WNW'(rn_s5[r]) * WNW'($signed({1'b0, wt_s5}));
				end
			end
			rn_s6 <= rn_s5;
		end
	end

endmodule

// ===== rtl/quaternion_vertex_skinning_core.sv =====
// Top level of the skinning core: palette banks, influence lanes, blending and output stage.
// A skin item passes through the stage registers s1 to s8 and shows as a valid result from the s8 register.
// Throughput: one item per cycle; the whole eight-stage pipeline holds while a result is stalled.
// Load items write the palette at acceptance and are visible to the very next skin item.
// Reset clears the valid bits and the mode register; the palette is undefined until loaded.
module quaternion_vertex_skinning_core #(
	parameter int MAX_BONES  = qvs_pkg::MAX_BONES_DEF,
	parameter int INFLUENCES = qvs_pkg::INFLUENCES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	output logic               vtx_stall,
	input  qvs_pkg::vtx_item_t vtx_item,
	output logic               res_valid,
	input  logic               res_stall,
	output qvs_pkg::res_item_t res_item,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data
);
	import qvs_pkg::*;

	logic en;
	logic accept;
	logic cfg_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	bone_entry_t wr_entry;
	bone_entry_t entry_s1 [INFLUENCES];

	logic signed [PW-1:0] pos_s1 [3];
	logic signed [PW-1:0] pos_s2 [3];
	logic signed [PW-1:0] pos_s3 [3];
	logic signed [VW-1:0] nrm_s1 [3];
	logic signed [VW-1:0] nrm_s2 [3];
	logic signed [VW-1:0] nrm_s3 [3];
	logic [PACKED_INFL*WW-1:0] wts_s1, wts_s2, wts_s3, wts_s4, wts_s5;

	logic signed [WPW-1:0] wpos_s6 [INFLUENCES][3];
	logic signed [WNW-1:0] wnrm_s6 [INFLUENCES][3];
	logic signed [RNW-1:0] rn_s6 [INFLUENCES][3];

	logic signed [AW-1:0]  pacc [3];
	logic signed [ANW-1:0] nacc [3];
	logic signed [AW-1:0]  pacc_s7 [3];
	logic signed [ANW-1:0] nacc_s7 [3];
	logic signed [VW-1:0]  nfirst_s7 [3];
	logic signed [AW-1:0]  prnd [3];
	logic signed [ANW-1:0] nrnd [3];
	logic signed [ARW-1:0] psh [3];
	logic signed [ANRW-1:0] nsh [3];
	res_item_t out_s8;

	assign en        = !(v_s8 && res_stall);
	assign vtx_stall = !en;
	assign accept    = vtx_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 1'b0;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && (vtx_item.operation == OP_SKIN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	assign wr_entry.qx = vtx_item.vec_x;
	assign wr_entry.qy = vtx_item.vec_y;
	assign wr_entry.qz = vtx_item.vec_z;
	assign wr_entry.qw = vtx_item.quat_w;
	assign wr_entry.tx = vtx_item.pos_x;
	assign wr_entry.ty = vtx_item.pos_y;
	assign wr_entry.tz = vtx_item.pos_z;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1[0] <= vtx_item.pos_x;
			pos_s1[1] <= vtx_item.pos_y;
			pos_s1[2] <= vtx_item.pos_z;
			nrm_s1[0] <= vtx_item.vec_x;
			nrm_s1[1] <= vtx_item.vec_y;
			nrm_s1[2] <= vtx_item.vec_z;
			wts_s1    <= vtx_item.influence_weights;
			pos_s2    <= pos_s1;
			pos_s3    <= pos_s2;
			nrm_s2    <= nrm_s1;
			nrm_s3    <= nrm_s2;
			wts_s2    <= wts_s1;
			wts_s3    <= wts_s2;
			wts_s4    <= wts_s3;
			wts_s5    <= wts_s4;
		end
	end

	for (genvar j = 0; j < INFLUENCES; j++) begin : g_lane
		qvs_palette #(
			.MAX_BONES(MAX_BONES)
		) u_palette (
			.clk      (clk),
			.wr_en    (accept && (vtx_item.operation == OP_LOAD)),
			.wr_idx   (vtx_item.bone_slot),
			.wr_entry (wr_entry),
			.rd_en    (en),
			.rd_idx   (vtx_item.influence_bones[BIW*j +: BIW]),
			.rd_entry (entry_s1[j])
		);

		qvs_lane u_lane (
			.clk      (clk),
			.en       (en),
			.entry_s1 (entry_s1[j]),
			.pos_s3   (pos_s3),
			.nrm_s3   (nrm_s3),
			.wt_s5    (wts_s5[WW*j +: WW]),
			.wpos_s6  (wpos_s6[j]),
			.wnrm_s6  (wnrm_s6[j]),
			.rn_s6    (rn_s6[j])
		);
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			pacc[r] = '0;
			nacc[r] = '0;
			for (int j = 0; j < INFLUENCES; j++) begin
				pacc[r] = pacc[r] + AW'(wpos_s6[j][r]);
				nacc[r] = nacc[r] + ANW'(wnrm_s6[j][r]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pacc_s7[r]   <= pacc[r];
				nacc_s7[r]   <= nacc[r];
				nfirst_s7[r] <= sat_rn(rn_s6[0][r]);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			prnd[r] = pacc_s7[r] + (AW'(1) <<< 15);
			nrnd[r] = nacc_s7[r] + (ANW'(1) <<< 15);
			psh[r]  = prnd[r][AW-1:16];
			nsh[r]  = nrnd[r][ANW-1:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s8.out_pos_x    <= sat_pos(psh[0]);
			out_s8.out_pos_y    <= sat_pos(psh[1]);
			out_s8.out_pos_z    <= sat_pos(psh[2]);
			out_s8.out_normal_x <= cfg_q ? nfirst_s7[0] : sat_nacc(nsh[0]);
			out_s8.out_normal_y <= cfg_q ? nfirst_s7[1] : sat_nacc(nsh[1]);
			out_s8.out_normal_z <= cfg_q ? nfirst_s7[2] : sat_nacc(nsh[2]);
		end
	end

	assign res_valid = v_s8;
	assign res_item  = out_s8;

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && vtx_item.operation == OP_LOAD) |=> !v_s1)
		else $error("A load item entered the result pipeline.");

	a_skin_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && vtx_item.operation == OP_SKIN) |=> v_s1)
		else $error("An accepted skin item was lost at the first stage.");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && res_stall) |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7}))
		else $error("The pipeline moved while the result was stalled.");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && en) |=> res_valid)
		else $error("An item in the last blending stage did not reach the output.");

endmodule

// ===== sim/quaternion_vertex_skinning_checker.sv =====
// Checker that predicts skinned vertices from observed items and compares them with results.
`timescale 1ns / 100ps
module quaternion_vertex_skinning_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	input  logic               vtx_stall,
	input  qvs_pkg::vtx_item_t vtx_item,
	input  logic               res_valid,
	input  logic               res_stall,
	input  qvs_pkg::res_item_t res_item,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	output int                 fail_count,
	output int                 pending
);
	import qvs_pkg::*;

	logic signed [31:0] pal_t [0:255][0:2];
	logic signed [15:0] pal_q [0:255][0:3];
	logic               first_bone_mode;
	res_item_t          skinned_q [$];
	int                 result_count;

	function automatic longint round_shift(input longint v, input int s);
		longint w;
		w = v + (longint'(1) << (s - 1));
		return w >>> s;
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic void bone_rotate(input int idx, input longint v[3], output longint r[3],
		output longint t[3]);
		longint x, y, z, w;
		longint m[9];
		x = pal_q[idx][0];
		y = pal_q[idx][1];
		z = pal_q[idx][2];
		w = pal_q[idx][3];
		for (int i = 0; i < 3; i++) t[i] = pal_t[idx][i];
		m[0] = (longint'(1) << 28) - 2 * (y * y + z * z);
		m[1] = 2 * (x * y - w * z);
		m[2] = 2 * (x * z + w * y);
		m[3] = 2 * (x * y + w * z);
		m[4] = (longint'(1) << 28) - 2 * (x * x + z * z);
		m[5] = 2 * (y * z - w * x);
		m[6] = 2 * (x * z - w * y);
		m[7] = 2 * (y * z + w * x);
		m[8] = (longint'(1) << 28) - 2 * (x * x + y * y);
		for (int i = 0; i < 9; i++) m[i] = round_shift(m[i], 14);
		for (int i = 0; i < 3; i++)
			r[i] = round_shift(m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2], 14);
	endfunction

	function automatic res_item_t skin_vertex(input vtx_item_t it);
		longint p[3], n[3], rp[3], rn[3], t[3];
		longint pacc[3], nacc[3];
		longint wt;
		res_item_t r;
		p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
		n = '{longint'(it.vec_x), longint'(it.vec_y), longint'(it.vec_z)};
		pacc = '{0, 0, 0};
		nacc = '{0, 0, 0};
		for (int j = 0; j < 4; j++) begin
			wt = longint'(it.influence_weights[16*j +: 16]);
			if (wt != 0) begin
				bone_rotate(int'(it.influence_bones[8*j +: 8]), p, rp, t);
				bone_rotate(int'(it.influence_bones[8*j +: 8]), n, rn, t);
				for (int i = 0; i < 3; i++) begin
					pacc[i] += (rp[i] + t[i]) * wt;
					nacc[i] += rn[i] * wt;
				end
			end
		end
		r.out_pos_x = 32'(clamp(round_shift(pacc[0], 16), 32));
		r.out_pos_y = 32'(clamp(round_shift(pacc[1], 16), 32));
		r.out_pos_z = 32'(clamp(round_shift(pacc[2], 16), 32));
		r.out_normal_x = 16'(clamp(round_shift(nacc[0], 16), 16));
		r.out_normal_y = 16'(clamp(round_shift(nacc[1], 16), 16));
		r.out_normal_z = 16'(clamp(round_shift(nacc[2], 16), 16));
		if (first_bone_mode) begin
			bone_rotate(int'(it.influence_bones[7:0]), n, rn, t);
			r.out_normal_x = 16'(clamp(rn[0], 16));
			r.out_normal_y = 16'(clamp(rn[1], 16));
			r.out_normal_z = 16'(clamp(rn[2], 16));
		end
		return r;
	endfunction

	assign pending = skinned_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_item_t exp_r;
		if (!arst_n) begin
			first_bone_mode <= 1'b0;
			fail_count = 0;
			result_count = 0;
			skinned_q.delete();
		end else begin
			if (res_valid && !res_stall) begin
				result_count++;
				if (skinned_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, res_item);
					fail_count++;
				end else begin
					exp_r = skinned_q.pop_front();
					if (exp_r !== res_item) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_r, res_item);
						fail_count++;
					end
				end
			end
			if (vtx_valid && !vtx_stall) begin
				if (vtx_item.operation == OP_LOAD) begin
					pal_t[vtx_item.bone_slot] = '{vtx_item.pos_x, vtx_item.pos_y, vtx_item.pos_z};
					pal_q[vtx_item.bone_slot] = '{vtx_item.vec_x, vtx_item.vec_y,
						vtx_item.vec_z, vtx_item.quat_w};
				end else begin
					skinned_q = {skinned_q, skin_vertex(vtx_item)};
				end
			end
			if (cfg_wr_en) first_bone_mode <= cfg_wr_data;
		end
	end

endmodule

// ===== sim/quaternion_vertex_skinning_core_tb.sv =====
// Testbench top that drives load and skin items through the skinning core and gives the verdict.
`timescale 1ns / 100ps
module quaternion_vertex_skinning_core_tb;
	import qvs_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      vtx_valid;
	logic      vtx_stall;
	vtx_item_t vtx_item;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_item;
	logic      cfg_wr_en;
	logic      cfg_wr_data;
	int        fail_count;
	int        pending;
	bit        loaded [0:255];
	int        loaded_list [$];
	int        skin_count;
	int        stall_mode;

	quaternion_vertex_skinning_core u_top (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx_item(vtx_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	quaternion_vertex_skinning_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx_item(vtx_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			default: res_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send(input vtx_item_t it);
		@(negedge clk);
		vtx_valid <= 1'b1;
		vtx_item <= it;
		@(posedge clk);
		while (vtx_stall) @(posedge clk);
		if (it.operation == OP_LOAD && !loaded[it.bone_slot]) begin
			loaded[it.bone_slot] = 1'b1;
			loaded_list = {loaded_list, int'(it.bone_slot)};
		end
		if (it.operation == OP_SKIN) skin_count++;
		if ($urandom_range(0, 3) == 0) begin
			@(negedge clk);
			vtx_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic write_mode(input logic v);
		@(negedge clk);
		vtx_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic vtx_item_t random_load(input logic [7:0] slot, input bit unit);
		vtx_item_t it;
		int a;
		it = '0;
		it.operation = OP_LOAD;
		it.bone_slot = slot;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.pos_z = $urandom;
		it.vec_x = 16'($urandom);
		it.vec_y = 16'($urandom);
		it.vec_z = 16'($urandom);
		it.quat_w = 16'($urandom);
		it.influence_bones = $urandom;
		it.influence_weights = {$urandom, $urandom};
		if (unit) begin
			a = $urandom_range(0, 3);
			it.pos_x = $signed(it.pos_x) >>> 8;
			it.pos_y = $signed(it.pos_y) >>> 8;
			it.pos_z = $signed(it.pos_z) >>> 8;
			it.vec_x = $signed(it.vec_x) >>> 2;
			it.vec_y = $signed(it.vec_y) >>> 2;
			it.vec_z = $signed(it.vec_z) >>> 2;
			it.quat_w = $signed(it.quat_w) >>> 1;
			if (a == 0) it.quat_w = 16'sd16384;
		end
		return it;
	endfunction

	function automatic vtx_item_t random_skin(input bit extreme);
		vtx_item_t it;
		logic [15:0] w[4];
		int left;
		it = random_load(8'd0, !extreme);
		it.operation = OP_SKIN;
		it.bone_slot = 8'($urandom);
		it.quat_w = 16'($urandom);
		for (int j = 0; j < 4; j++) begin
			if ($urandom_range(0, 9) == 0) it.influence_bones[8*j +: 8] = 8'($urandom);
			else it.influence_bones[8*j +: 8] = 8'(loaded_list[$urandom_range(0,
				loaded_list.size() - 1)]);
		end
		if (extreme) begin
			it.influence_weights = {$urandom, $urandom};
		end else begin
			left = 65536;
			for (int j = 0; j < 3; j++) begin
				w[j] = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0,
					left > 65535 ? 65535 : left));
				left -= w[j];
			end
			w[3] = left > 65535 ? 16'hFFFF : left[15:0];
			it.influence_weights = {w[3], w[2], w[1], w[0]};
		end
		for (int j = 0; j < 4; j++)
			if (it.influence_weights[16*j +: 16] != 0 && !loaded[it.influence_bones[8*j +: 8]])
				it.influence_bones[8*j +: 8] = 8'(loaded_list[0]);
		if (!loaded[it.influence_bones[7:0]]) it.influence_bones[7:0] = 8'(loaded_list[0]);
		return it;
	endfunction

	initial begin
		vtx_item_t it;
		int burst;
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		vtx_item = '0;
		res_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		stall_mode = 0;
		skin_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		it = '0;
		it.operation = OP_LOAD;
		it.quat_w = 16'sd16384;
		send(it);
		it.bone_slot = 8'd255;
		it.pos_x = 32'sh7FFFFFFF;
		it.pos_y = 32'sh80000000;
		it.pos_z = 32'sh7FFFFFFF;
		it.vec_x = 16'sh7FFF;
		it.vec_y = 16'sh8000;
		it.vec_z = 16'sh7FFF;
		it.quat_w = 16'sh8000;
		send(it);
		it = '0;
		it.operation = OP_LOAD;
		it.bone_slot = 8'd1;
		send(it);
		for (int k = 0; k < 6; k++) send(random_load(8'($urandom_range(2, 20)), 1));
		it = '0;
		it.operation = OP_SKIN;
		it.pos_x = 32'sh00010000;
		it.vec_x = 16'sh4000;
		it.influence_weights = 64'h0000_0000_0000_FFFF;
		send(it);
		it.influence_bones = 32'h00_00_01_FF;
		it.influence_weights = 64'h4000_4000_4000_4000;
		send(it);
		it.pos_x = 32'sh7FFFFFFF;
		it.pos_y = 32'sh80000000;
		it.pos_z = 32'sh7FFFFFFF;
		it.vec_x = 16'sh7FFF;
		it.vec_y = 16'sh8000;
		it.vec_z = 16'sh7FFF;
		it.quat_w = 16'sh7FFF;
		it.bone_slot = 8'hFF;
		it.influence_bones = 32'hFFFF_FFFF;
		it.influence_weights = 64'hFFFF_FFFF_FFFF_FFFF;
		send(it);
		it.influence_bones = 32'h0000_0000;
		it.influence_weights = 64'h0000_0000_0000_0000;
		send(it);
		for (int k = 0; k < 4; k++) send(random_skin(1));

		for (int phase = 0; phase < 4; phase++) begin
			write_mode(phase[0] ^ 1'b1);
			for (int k = 0; k < 250; k++) begin
				if ($urandom_range(0, 7) == 0) send(random_load(8'($urandom), 1));
				else send(random_skin($urandom_range(0, 5) == 0));
			end
		end
		write_mode(1'b0);
		for (int k = 0; k < 20; k++) send(random_skin(0));

		@(negedge clk);
		vtx_valid <= 1'b0;
		burst = 0;
		while (pending != 0 && burst < 100000) begin
			@(negedge clk);
			burst++;
		end
		repeat (20) @(negedge clk);
		$display("Covered %0d skinned vertices with both normal modes, loads and stalls.",
			skin_count);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
